// ===== design/tsr_pkg.sv =====
// Shared constants, types and command/status structs for the triangle scanline rasterizer.
package tsr_pkg;

    localparam int COORD_BITS = 12;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * DIFF_BITS;
    localparam int STEP_BITS  = $clog2(PROD_BITS + 1);

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_PULL = 1'b1;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIFF_BITS-1:0]  diff_t;
    typedef logic signed [PROD_BITS-1:0]  prod_t;

    typedef struct packed {
        logic load;
        logic pull;
        logic mul;
        logic prep;
        logic step;
        logic fin;
    } ctrl_cmd_t;

    typedef struct packed {
        logic active;
        logic span_more;
        logic is_last;
    } dp_status_t;

endpackage

// ===== design/triangle_scanline_rasterizer_core.sv =====
// Top level of the triangle scanline rasterizer: controller, datapath and checks.
// An item is taken when start is high and busy is low. A load item (opcode 0) sorts the
// vertices and then holds busy while the first span's short- and long-edge x values are found: a
// multiply step, a setup step, one quotient bit per cycle in the two restoring dividers, a
// finish step. A pull item (opcode 1) puts its point on point_x/point_y with strobe high
// in the next cycle; pulls within a span can follow every cycle. A pull that closes a span
// starts the next span's setup, which again holds busy. Results are not held: the
// receiver must take each one in its strobe cycle.
module triangle_scanline_rasterizer_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  logic            opcode,
    input  tsr_pkg::coord_t vertex_a_x,
    input  tsr_pkg::coord_t vertex_a_y,
    input  tsr_pkg::coord_t vertex_b_x,
    input  tsr_pkg::coord_t vertex_b_y,
    input  tsr_pkg::coord_t vertex_c_x,
    input  tsr_pkg::coord_t vertex_c_y,
    output logic            strobe,
    output tsr_pkg::coord_t point_x,
    output tsr_pkg::coord_t point_y,
    output logic            point_valid,
    output logic            last_point
);
    import tsr_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    tsr_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (opcode),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    tsr_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .vertex_a_x  (vertex_a_x),
        .vertex_a_y  (vertex_a_y),
        .vertex_b_x  (vertex_b_x),
        .vertex_b_y  (vertex_b_y),
        .vertex_c_x  (vertex_c_x),
        .vertex_c_y  (vertex_c_y),
        .status      (status),
        .point_x     (point_x),
        .point_y     (point_y),
        .point_valid (point_valid),
        .last_point  (last_point),
        .strobe      (strobe)
    );

    // a result only follows an accepted pull
    a_strobe_after_pull: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(start && !busy && (opcode == OP_PULL)))
        else $error("strobe without an accepted pull");

    // setup only starts from an accepted item
    a_busy_from_item: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without an accepted item");

    // the final point ends the triangle: the next pull before a load is invalid
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last_point) |-> (point_valid && !status.active))
        else $error("triangle still active after last point");

endmodule

// ===== design/tsr_div.sv =====
// Restoring divider, one quotient bit per step, truncating toward zero.
module tsr_div (
    input  logic           clk,
    input  logic           init,
    input  logic           step,
    input  tsr_pkg::prod_t num,
    input  tsr_pkg::diff_t den,
    output tsr_pkg::diff_t quotient
);
    import tsr_pkg::*;

    logic [PROD_BITS-1:0] quo_reg;
    logic [PROD_BITS-1:0] quo_next;
    logic [DIFF_BITS-1:0] rem_reg;
    logic [DIFF_BITS-1:0] rem_next;
    logic                 neg_reg;
    logic                 neg_next;
    logic [DIFF_BITS:0]   trial;
    logic [DIFF_BITS:0]   trial_sub;
    logic                 fits;
    prod_t                num_abs;
    diff_t                q_mag;

    assign num_abs   = num[PROD_BITS-1] ? -num : num;
    assign trial     = {rem_reg, quo_reg[PROD_BITS-1]};
    assign trial_sub = trial - {1'b0, den};
    assign fits      = trial >= {1'b0, den};

    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        neg_next = neg_reg;
        if (init)
        begin
            quo_next = num_abs;
            rem_next = '0;
            neg_next = num[PROD_BITS-1];
        end
        else if (step)
        begin
            quo_next = {quo_reg[PROD_BITS-2:0], fits};
            rem_next = fits ? trial_sub[DIFF_BITS-1:0] : trial[DIFF_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
    end

    assign q_mag    = $signed(quo_reg[DIFF_BITS-1:0]);
    assign quotient = neg_reg ? -q_mag : q_mag;

endmodule

// ===== design/tsr_datapath.sv =====
// Datapath: vertex sort, row/column walk, edge interpolation and output registers.
module tsr_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  tsr_pkg::ctrl_cmd_t  cmd,
    input  tsr_pkg::coord_t     vertex_a_x,
    input  tsr_pkg::coord_t     vertex_a_y,
    input  tsr_pkg::coord_t     vertex_b_x,
    input  tsr_pkg::coord_t     vertex_b_y,
    input  tsr_pkg::coord_t     vertex_c_x,
    input  tsr_pkg::coord_t     vertex_c_y,
    output tsr_pkg::dp_status_t status,
    output tsr_pkg::coord_t     point_x,
    output tsr_pkg::coord_t     point_y,
    output logic                point_valid,
    output logic                last_point,
    output logic                strobe
);
    import tsr_pkg::*;

    coord_t sx [3];
    coord_t sy [3];
    coord_t tx;
    coord_t ty;

    coord_t vx_reg [3];
    coord_t vy_reg [3];
    coord_t vx_next [3];
    coord_t vy_next [3];
    coord_t row_y_reg, row_y_next;
    coord_t column_reg, column_next;
    coord_t span_end_reg, span_end_next;
    logic   lower_reg, lower_next;
    logic   active_reg, active_next;

    coord_t point_x_reg, point_x_next;
    coord_t point_y_reg, point_y_next;
    logic   point_valid_reg, point_valid_next;
    logic   last_point_reg, last_point_next;
    logic   strobe_reg;

    logic   is_last;
    logic   span_more;

    // edge setup
    coord_t s_ya, s_xa, s_yb, s_xb;
    diff_t  s_dx, s_dyr, s_den, l_dx, l_dyr, l_den;
    prod_t  s_prod, l_prod;
    prod_t  s_prod_reg, l_prod_reg;
    diff_t  s_den_reg, l_den_reg;
    coord_t s_xa_reg, s_xb_reg, l_xa_reg, l_xb_reg;
    logic   s_flat_reg, l_flat_reg;
    diff_t  s_q, l_q;
    diff_t  s_edge_full, l_edge_full;
    coord_t s_edge, l_edge;

    // three compare-and-swap steps on y
    always_comb
    begin
        sx[0] = vertex_a_x;
        sy[0] = vertex_a_y;
        sx[1] = vertex_b_x;
        sy[1] = vertex_b_y;
        sx[2] = vertex_c_x;
        sy[2] = vertex_c_y;
        tx    = '0;
        ty    = '0;
        if (sy[0] > sy[1])
        begin
            tx = sx[0]; ty = sy[0];
            sx[0] = sx[1]; sy[0] = sy[1];
            sx[1] = tx; sy[1] = ty;
        end
        if (sy[1] > sy[2])
        begin
            tx = sx[1]; ty = sy[1];
            sx[1] = sx[2]; sy[1] = sy[2];
            sx[2] = tx; sy[2] = ty;
        end
        if (sy[0] > sy[1])
        begin
            tx = sx[0]; ty = sy[0];
            sx[0] = sx[1]; sy[0] = sy[1];
            sx[1] = tx; sy[1] = ty;
        end
    end

    assign span_more = column_reg < span_end_reg;
    assign is_last   = lower_reg && (column_reg >= span_end_reg) && (row_y_reg >= vy_reg[2]);

    assign status.active    = active_reg;
    assign status.span_more = span_more;
    assign status.is_last   = is_last;

    // upper or lower short edge, and the long edge
    assign s_ya = lower_reg ? vy_reg[1] : vy_reg[0];
    assign s_xa = lower_reg ? vx_reg[1] : vx_reg[0];
    assign s_yb = lower_reg ? vy_reg[2] : vy_reg[1];
    assign s_xb = lower_reg ? vx_reg[2] : vx_reg[1];

    assign s_dx   = diff_t'(s_xb) - diff_t'(s_xa);
    assign s_dyr  = diff_t'(row_y_reg) - diff_t'(s_ya);
    assign s_den  = diff_t'(s_yb) - diff_t'(s_ya);
    assign l_dx   = diff_t'(vx_reg[2]) - diff_t'(vx_reg[0]);
    assign l_dyr  = diff_t'(row_y_reg) - diff_t'(vy_reg[0]);
    assign l_den  = diff_t'(vy_reg[2]) - diff_t'(vy_reg[0]);
    assign s_prod = s_dx * s_dyr;
    assign l_prod = l_dx * l_dyr;

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            s_prod_reg <= s_prod;
            s_den_reg  <= s_den;
            s_xa_reg   <= s_xa;
            s_xb_reg   <= s_xb;
            s_flat_reg <= (s_yb == s_ya);
            l_prod_reg <= l_prod;
            l_den_reg  <= l_den;
            l_xa_reg   <= vx_reg[0];
            l_xb_reg   <= vx_reg[2];
            l_flat_reg <= (vy_reg[2] == vy_reg[0]);
        end
    end

    tsr_div u_short_div (
        .clk      (clk),
        .init     (cmd.prep),
        .step     (cmd.step),
        .num      (s_prod_reg),
        .den      (s_den_reg),
        .quotient (s_q)
    );

    tsr_div u_long_div (
        .clk      (clk),
        .init     (cmd.prep),
        .step     (cmd.step),
        .num      (l_prod_reg),
        .den      (l_den_reg),
        .quotient (l_q)
    );

    // flat edge takes its far vertex x
    assign s_edge_full = s_flat_reg ? diff_t'(s_xb_reg) : diff_t'(s_xa_reg) + s_q;
    assign l_edge_full = l_flat_reg ? diff_t'(l_xb_reg) : diff_t'(l_xa_reg) + l_q;
    assign s_edge      = s_edge_full[COORD_BITS-1:0];
    assign l_edge      = l_edge_full[COORD_BITS-1:0];

    always_comb
    begin
        vx_next          = vx_reg;
        vy_next          = vy_reg;
        row_y_next       = row_y_reg;
        column_next      = column_reg;
        span_end_next    = span_end_reg;
        lower_next       = lower_reg;
        active_next      = active_reg;
        point_x_next     = point_x_reg;
        point_y_next     = point_y_reg;
        point_valid_next = point_valid_reg;
        last_point_next  = last_point_reg;

        if (cmd.load)
        begin
            vx_next     = sx;
            vy_next     = sy;
            row_y_next  = sy[0];
            lower_next  = 1'b0;
            active_next = 1'b1;
        end
        else if (cmd.pull)
        begin
            point_valid_next = active_reg;
            point_x_next     = active_reg ? column_reg : '0;
            point_y_next     = active_reg ? row_y_reg : '0;
            last_point_next  = active_reg && is_last;
            if (active_reg)
            begin
                if (is_last)
                begin
                    active_next = 1'b0;
                end
                else if (span_more)
                begin
                    column_next = column_reg + coord_t'(1);
                end
                else if (!lower_reg)
                begin
                    if (row_y_reg < vy_reg[1])
                    begin
                        row_y_next = row_y_reg + coord_t'(1);
                    end
                    else
                    begin
                        lower_next = 1'b1;
                    end
                end
                else
                begin
                    row_y_next = row_y_reg + coord_t'(1);
                end
            end
        end
        else if (cmd.fin)
        begin
            column_next   = (s_edge > l_edge) ? l_edge : s_edge;
            span_end_next = (s_edge > l_edge) ? s_edge : l_edge;
        end
    end

    always_ff @(posedge clk)
    begin
        vx_reg          <= vx_next;
        vy_reg          <= vy_next;
        row_y_reg       <= row_y_next;
        column_reg      <= column_next;
        span_end_reg    <= span_end_next;
        point_x_reg     <= point_x_next;
        point_y_reg     <= point_y_next;
        point_valid_reg <= point_valid_next;
        last_point_reg  <= last_point_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_reg  <= 1'b0;
            active_reg <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            lower_reg  <= lower_next;
            active_reg <= active_next;
            strobe_reg <= cmd.pull;
        end
    end

    assign point_x     = point_x_reg;
    assign point_y     = point_y_reg;
    assign point_valid = point_valid_reg;
    assign last_point  = last_point_reg;
    assign strobe      = strobe_reg;

endmodule

// ===== design/tsr_ctrl.sv =====
// Controller: accepts items and sequences span setup (multiply, divide, finish).
module tsr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                opcode,
    input  tsr_pkg::dp_status_t status,
    output tsr_pkg::ctrl_cmd_t  cmd,
    output logic                busy
);
    import tsr_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_PREP = 5'b00100,
        S_DIV  = 5'b01000,
        S_FIN  = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [STEP_BITS-1:0] step_cnt_reg, step_cnt_next;

    always_comb
    begin
        state_next    = state_reg;
        step_cnt_next = step_cnt_reg;
        cmd           = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (opcode == OP_LOAD)
                    begin
                        cmd.load   = 1'b1;
                        state_next = S_MUL;
                    end
                    else
                    begin
                        cmd.pull = 1'b1;
                        if (status.active && !status.is_last && !status.span_more)
                        begin
                            state_next = S_MUL;
                        end
                    end
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_PREP;
            end
            S_PREP:
            begin
                cmd.prep      = 1'b1;
                step_cnt_next = '0;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                cmd.step      = 1'b1;
                step_cnt_next = step_cnt_reg + 1'b1;
                if (step_cnt_reg == STEP_BITS'(PROD_BITS - 1))
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                cmd.fin    = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            step_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            step_cnt_reg <= step_cnt_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ===== tb/triangle_scanline_rasterizer_core_test.sv =====
// Testbench for triangle_scanline_rasterizer_core: load/pull items vs a scanline point predictor.
`timescale 1ns / 100ps

module triangle_scanline_rasterizer_core_test;
    import tsr_pkg::*;

    typedef struct packed {
        coord_t ax;
        coord_t ay;
        coord_t bx;
        coord_t by;
        coord_t cx;
        coord_t cy;
    } triangle_t;

    typedef struct {
        coord_t x;
        coord_t y;
        logic   valid;
        logic   last;
    } point_t;

    class span_point_scoreboard;
        point_t expected_points[$];
        int     errors;
        int     vx[3];
        int     vy[3];
        int     row;
        int     col;
        int     span_end;
        bit     lower_half;
        bit     drawing;

        task report(string what);
            $display("mismatch at %0t: %s", $time, what);
            errors++;
        endtask

        function int edge_x_at(int y, int ya, int xa, int yb, int xb);
            return xa + (xb - xa) * (y - ya) / (yb - ya);
        endfunction

        function void open_span();
            int s;
            int e;
            if (!lower_half)
            begin
                if (vy[1] != vy[0])
                    s = edge_x_at(row, vy[0], vx[0], vy[1], vx[1]);
                else
                    s = vx[1];
            end
            else
            begin
                if (vy[1] != vy[2])
                    s = edge_x_at(row, vy[1], vx[1], vy[2], vx[2]);
                else
                    s = vx[2];
            end
            if (vy[2] != vy[0])
                e = edge_x_at(row, vy[0], vx[0], vy[2], vx[2]);
            else
                e = vx[2];
            col      = (s < e) ? s : e;
            span_end = (s < e) ? e : s;
        endfunction

        function void order_pair(int i, int j);
            int tx;
            int ty;
            if (vy[i] > vy[j])
            begin
                tx    = vx[i];
                ty    = vy[i];
                vx[i] = vx[j];
                vy[i] = vy[j];
                vx[j] = tx;
                vy[j] = ty;
            end
        endfunction

        function void note_item(logic op, triangle_t t);
            point_t p;
            if (op == OP_LOAD)
            begin
                vx[0] = t.ax;
                vy[0] = t.ay;
                vx[1] = t.bx;
                vy[1] = t.by;
                vx[2] = t.cx;
                vy[2] = t.cy;
                order_pair(0, 1);
                order_pair(1, 2);
                order_pair(0, 1);
                lower_half = 1'b0;
                row        = vy[0];
                open_span();
                drawing = 1'b1;
            end
            else if (!drawing)
            begin
                p.x     = '0;
                p.y     = '0;
                p.valid = 1'b0;
                p.last  = 1'b0;
                expected_points = {expected_points, p};
            end
            else
            begin
                p.x     = coord_t'(col);
                p.y     = coord_t'(row);
                p.valid = 1'b1;
                p.last  = lower_half && col >= span_end && row >= vy[2];
                expected_points = {expected_points, p};
                if (p.last)
                    drawing = 1'b0;
                else if (col < span_end)
                    col++;
                else if (!lower_half)
                begin
                    if (row < vy[1])
                        row++;
                    else
                        lower_half = 1'b1;
                    open_span();
                end
                else
                begin
                    row++;
                    open_span();
                end
            end
        endfunction

        task check_point(coord_t x, coord_t y, logic valid, logic last);
            point_t p;
            if (expected_points.size() == 0)
                report($sformatf("unexpected point x=%0d y=%0d valid=%b", x, y, valid));
            else
            begin
                p = expected_points.pop_front();
                if (valid !== p.valid)
                    report($sformatf("point_valid %b, expected %b", valid, p.valid));
                if (x !== p.x)
                    report($sformatf("point_x %0d, expected %0d", x, p.x));
                if (y !== p.y)
                    report($sformatf("point_y %0d, expected %0d", y, p.y));
                if (last !== p.last)
                    report($sformatf("last_point %b, expected %b at (%0d,%0d)",
                                     last, p.last, p.x, p.y));
            end
        endtask
    endclass

    logic      clk = 1'b0;
    logic      rst_n;
    logic      start;
    logic      busy;
    logic      opcode;
    triangle_t tri_in;
    logic      strobe;
    coord_t    point_x;
    coord_t    point_y;
    logic      point_valid;
    logic      last_point;

    span_point_scoreboard sb;
    int items_sent;
    bit gap_free;

    triangle_scanline_rasterizer_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .opcode      (opcode),
        .vertex_a_x  (tri_in.ax),
        .vertex_a_y  (tri_in.ay),
        .vertex_b_x  (tri_in.bx),
        .vertex_b_y  (tri_in.by),
        .vertex_c_x  (tri_in.cx),
        .vertex_c_y  (tri_in.cy),
        .strobe      (strobe),
        .point_x     (point_x),
        .point_y     (point_y),
        .point_valid (point_valid),
        .last_point  (last_point)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && strobe === 1'b1)
            sb.check_point(point_x, point_y, point_valid, last_point);
    end

    function automatic triangle_t random_triangle();
        logic [95:0] raw;
        raw = {$urandom(), $urandom(), $urandom()};
        return raw[$bits(triangle_t)-1:0];
    endfunction

    function automatic coord_t clamp_coord(int v);
        int lo;
        int hi;
        lo = -(1 << (COORD_BITS - 1));
        hi = (1 << (COORD_BITS - 1)) - 1;
        if (v < lo)
            v = lo;
        if (v > hi)
            v = hi;
        return coord_t'(v);
    endfunction

    // vertices scattered around one base point; base sometimes pinned to an edge or corner
    function automatic triangle_t local_triangle(int xs, int ys);
        triangle_t t;
        int bx;
        int by;
        bx = int'($urandom_range(0, 4095)) - 2048;
        by = int'($urandom_range(0, 4095)) - 2048;
        if ($urandom_range(0, 6) == 0)
            bx = $urandom_range(0, 1) ? 2047 : -2048;
        if ($urandom_range(0, 6) == 0)
            by = $urandom_range(0, 1) ? 2047 : -2048;
        t.ax = clamp_coord(bx + int'($urandom_range(0, 2 * xs)) - xs);
        t.ay = clamp_coord(by + int'($urandom_range(0, 2 * ys)) - ys);
        t.bx = clamp_coord(bx + int'($urandom_range(0, 2 * xs)) - xs);
        t.by = clamp_coord(by + int'($urandom_range(0, 2 * ys)) - ys);
        t.cx = clamp_coord(bx + int'($urandom_range(0, 2 * xs)) - xs);
        t.cy = clamp_coord(by + int'($urandom_range(0, 2 * ys)) - ys);
        return t;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (gap_free || r < 55)
            return 0;
        if (r < 90)
            return int'($urandom_range(1, 3));
        return int'($urandom_range(10, 60));
    endfunction

    task automatic idle_for(int cycles, bit drain);
        start  <= 1'b0;
        tri_in <= random_triangle();
        repeat (cycles) @(posedge clk);
        if (drain)
            while (sb.expected_points.size() != 0) @(posedge clk);
    endtask

    task automatic issue_item(logic op, triangle_t t);
        int g;
        start  <= 1'b1;
        opcode <= op;
        tri_in <= t;
        @(posedge clk);
        while (busy !== 1'b0) @(posedge clk);
        sb.note_item(op, t);
        items_sent++;
        g = pick_gap();
        if (g > 0)
            idle_for(g, 1'b0);
    endtask

    task automatic run_triangle(triangle_t t, int max_pulls);
        int n;
        n = 0;
        issue_item(OP_LOAD, t);
        while (sb.drawing && n < max_pulls)
        begin
            issue_item(OP_PULL, random_triangle());
            n++;
        end
    endtask

    initial
    begin
        int r;
        int next_drain;
        int next_style;
        sb         = new();
        items_sent = 0;
        gap_free   = 1'b0;
        rst_n  <= 1'b0;
        start  <= 1'b0;
        opcode <= OP_LOAD;
        tri_in <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // idle pull, extreme vertices, reload mid-triangle
        issue_item(OP_PULL, random_triangle());
        run_triangle({12'sd0 - 12'sd2048, 12'sd0 - 12'sd2048, 12'sd2047, 12'sd2047,
                      12'sd0 - 12'sd2048, 12'sd2047}, 2);
        run_triangle({12'sd2047, 12'sd2047, 12'sd0 - 12'sd2048, 12'sd0 - 12'sd2048,
                      12'sd2047, 12'sd0 - 12'sd2048}, 1);
        // single point, flat long edge, flat upper edge, flat lower edge
        run_triangle({-12'sd5, 12'sd7, -12'sd5, 12'sd7, -12'sd5, 12'sd7}, 10);
        run_triangle({12'sd2, -12'sd3, 12'sd0, -12'sd3, 12'sd1, -12'sd3}, 10);
        run_triangle({12'sd0, 12'sd1, 12'sd1, 12'sd0, 12'sd0, 12'sd0}, 10);
        run_triangle({12'sd1, 12'sd1, 12'sd0, 12'sd1, 12'sd0, 12'sd0}, 10);
        issue_item(OP_PULL, random_triangle());

        next_drain = 200;
        next_style = 0;
        while (items_sent < 1750)
        begin
            if (items_sent >= next_drain)
            begin
                idle_for(1, 1'b1);
                next_drain = items_sent + 230 + $urandom_range(0, 100);
            end
            if (items_sent >= next_style)
            begin
                gap_free   = ($urandom_range(0, 3) == 0);
                next_style = items_sent + $urandom_range(30, 120);
            end
            r = $urandom_range(0, 99);
            if (r < 65)
                run_triangle(local_triangle(8, 4),
                             ($urandom_range(0, 9) == 0) ? $urandom_range(1, 8) : 1000);
            else if (r < 78)
                run_triangle(local_triangle(60, 6),
                             ($urandom_range(0, 4) == 0) ? $urandom_range(1, 20) : 400);
            else if (r < 88)
                run_triangle(random_triangle(), $urandom_range(1, 10));
            else
                repeat ($urandom_range(1, 3))
                    issue_item($urandom_range(0, 3) == 0 ? OP_LOAD : OP_PULL,
                               random_triangle());
            if ($urandom_range(0, 3) == 0)
                issue_item(OP_PULL, random_triangle());
        end

        idle_for(1, 1'b1);
        repeat (40) @(posedge clk);
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
